[hdl/lc3_instruction_step_top_assert.svh]
// assertion macros for the lc3 instruction step block
`ifndef LC3_INSTRUCTION_STEP_TOP_ASSERT_SVH
`define LC3_INSTRUCTION_STEP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define LC3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define LC3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LC3_ASSERT(lbl, prop, msg)
`define LC3_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/lc3_pkg.sv]
// shared types, codes and helpers of the lc3 instruction step block
`default_nettype none
package lc3_pkg;
  localparam int unsigned MemDepthDef = 65536;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PEEK, S_FETCH, S_MEM1, S_MEM2
  } state_e;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_STEP = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;

  localparam logic [2:0] STAT_DONE    = 3'd0;
  localparam logic [2:0] STAT_HALT    = 3'd1;
  localparam logic [2:0] STAT_ILLEGAL = 3'd2;
  localparam logic [2:0] STAT_IGNORED = 3'd3;
  localparam logic [2:0] STAT_STRING  = 3'd4;

  localparam logic [3:0] OP_BR   = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_LD   = 4'h2;
  localparam logic [3:0] OP_ST   = 4'h3;
  localparam logic [3:0] OP_JSR  = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LDR  = 4'h6;
  localparam logic [3:0] OP_STR  = 4'h7;
  localparam logic [3:0] OP_RTI  = 4'h8;
  localparam logic [3:0] OP_NOT  = 4'h9;
  localparam logic [3:0] OP_LDI  = 4'hA;
  localparam logic [3:0] OP_STI  = 4'hB;
  localparam logic [3:0] OP_JMP  = 4'hC;
  localparam logic [3:0] OP_RSV  = 4'hD;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  localparam logic [7:0] VEC_GETC  = 8'h20;
  localparam logic [7:0] VEC_OUT   = 8'h21;
  localparam logic [7:0] VEC_PUTS  = 8'h22;
  localparam logic [7:0] VEC_IN    = 8'h23;
  localparam logic [7:0] VEC_PUTSP = 8'h24;
  localparam logic [7:0] VEC_HALT  = 8'h25;

  // n/z/p code of a value written to a register
  function automatic logic [2:0] cc_of(input logic [15:0] v);
    logic [2:0] c;
    if (v[15]) c = 3'b100;
    else if (v == 16'h0000) c = 3'b010;
    else c = 3'b001;
    return c;
  endfunction
endpackage
`default_nettype wire

[hdl/lc3_ram.sv]
// generic single-port ram with registered read
`default_nettype none
module lc3_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) mem[addr_i] <= wdata_i;
      else rdata_o <= mem[addr_i];
    end
  end
endmodule
`default_nettype wire

[hdl/lc3_instruction_step_top.sv]
// lc3 core stepping one instruction per transaction, with memory load and peek
// After reset the block sweeps the whole memory to zero, one word a cycle, and
// takes no transaction until the sweep ends (the start_pc write port is open
// meanwhile). A load writes memory from idle, a peek reads it in S_PEEK, a step
// fetches in S_FETCH, then passes S_MEM1 for LD, LDR, LDI and STI and S_MEM2
// for LDI; every access uses the single memory port. A result sits in an output
// register, and the next transaction is taken in the cycle that result leaves.
// MEM_DEPTH must be a power of two; addresses wrap modulo the depth.
`default_nettype none
`include "lc3_instruction_step_top_assert.svh"
module lc3_instruction_step_top
  import lc3_pkg::*;
#(
  parameter int unsigned MEM_DEPTH = MemDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] start_pc_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  kind_i,
  input  wire logic [15:0] address_i,
  input  wire logic [15:0] data_i,
  input  wire logic [7:0]  key_char_i,
  output logic             res_valid_o,
  input  wire logic        res_stall_i,
  output logic [15:0]      pc_out_o,
  output logic [15:0]      instr_word_o,
  output logic [2:0]       status_o,
  output logic             out_valid_o,
  output logic [7:0]       out_char_o,
  output logic [2:0]       cond_flags_o,
  output logic [15:0]      read_data_o
);
  localparam int unsigned AW = $clog2(MEM_DEPTH);

  state_e state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [15:0] pc_q, pc_d;
  logic [2:0]  cc_q, cc_d;
  logic        halt_q, halt_d;
  logic [15:0] rf_q [8];
  logic        rf_we;
  logic [2:0]  rf_wa;
  logic [15:0] rf_wd;
  logic [15:0] ins_q, ins_d;
  logic [7:0]  key_q, key_d;

  logic        ram_en, ram_we;
  logic [15:0] ram_addr, ram_wd, ram_rd;

  logic        res_vld_q, res_vld_d, res_load;
  logic [15:0] r_pc, r_ins, r_rdata;
  logic [2:0]  r_status, r_cc;
  logic        r_ov;
  logic [7:0]  r_oc;

  logic in_acc;

  // decode of the fetched word (FETCH) or the held word (later states)
  logic [15:0] ins, pcn, off9, off6, off11, imm5, opnd, sum;
  logic [3:0]  op;
  logic [2:0]  dr, sr1;

  assign in_stall_o  = (state_q != S_IDLE) || (res_vld_q && res_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign ins   = (state_q == S_FETCH) ? ram_rd : ins_q;
  assign op    = ins[15:12];
  assign dr    = ins[11:9];
  assign sr1   = ins[8:6];
  assign pcn   = pc_q + 16'd1;
  assign off9  = {{7{ins[8]}}, ins[8:0]};
  assign off6  = {{10{ins[5]}}, ins[5:0]};
  assign off11 = {{5{ins[10]}}, ins[10:0]};
  assign imm5  = {{11{ins[4]}}, ins[4:0]};
  assign opnd  = ins[5] ? imm5 : rf_q[ins[2:0]];
  assign sum   = rf_q[sr1] + opnd;

  lc3_ram #(.WIDTH(16), .DEPTH(MEM_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr[AW-1:0]),
    .wdata_i (ram_wd),
    .rdata_o (ram_rd)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == AW'(MEM_DEPTH - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_PEEK) state_d = S_PEEK;
          else if (kind_i == KIND_STEP && !halt_q) state_d = S_FETCH;
        end
      end
      S_PEEK: state_d = S_IDLE;
      S_FETCH: begin
        if (op == OP_LD || op == OP_LDR || op == OP_LDI || op == OP_STI) state_d = S_MEM1;
        else state_d = S_IDLE;
      end
      S_MEM1: state_d = (op == OP_LDI) ? S_MEM2 : S_IDLE;
      S_MEM2: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath control and results
  always_comb begin
    clr_d    = clr_q;
    pc_d     = pc_q;
    cc_d     = cc_q;
    halt_d   = halt_q;
    ins_d    = ins_q;
    key_d    = key_q;
    rf_we    = 1'b0;
    rf_wa    = dr;
    rf_wd    = 16'h0000;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = 16'h0000;
    ram_wd   = rf_q[dr];
    res_load = 1'b0;
    r_ins    = 16'h0000;
    r_status = STAT_DONE;
    r_ov     = 1'b0;
    r_oc     = 8'h00;
    r_rdata  = 16'h0000;
    unique case (state_q)
      S_CLEAR: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = 16'(clr_q);
        ram_wd   = 16'h0000;
        clr_d    = clr_q + AW'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          key_d = key_char_i;
          unique case (kind_i)
            KIND_LOAD: begin
              ram_en   = 1'b1;
              ram_we   = 1'b1;
              ram_addr = address_i;
              ram_wd   = data_i;
              res_load = 1'b1;
            end
            KIND_PEEK: begin
              ram_en   = 1'b1;
              ram_addr = address_i;
            end
            KIND_STEP: begin
              if (halt_q) begin
                res_load = 1'b1;
                r_status = STAT_IGNORED;
              end else begin
                ram_en   = 1'b1;
                ram_addr = pc_q;
              end
            end
            default: res_load = 1'b1;
          endcase
        end
      end
      S_PEEK: begin
        res_load = 1'b1;
        r_rdata  = ram_rd;
      end
      S_FETCH: begin
        ins_d = ram_rd;
        r_ins = ram_rd;
        pc_d  = pcn;
        res_load = 1'b1;
        unique case (op)
          OP_BR: if ((dr & cc_q) != 3'b000) pc_d = pcn + off9;
          OP_ADD: begin
            rf_we = 1'b1;
            rf_wd = sum;
          end
          OP_AND: begin
            rf_we = 1'b1;
            rf_wd = rf_q[sr1] & opnd;
          end
          OP_NOT: begin
            rf_we = 1'b1;
            rf_wd = ~rf_q[sr1];
          end
          OP_LEA: begin
            rf_we = 1'b1;
            rf_wd = pcn + off9;
          end
          OP_LD, OP_LDI, OP_STI: begin
            ram_en   = 1'b1;
            ram_addr = pcn + off9;
            res_load = 1'b0;
          end
          OP_LDR: begin
            ram_en   = 1'b1;
            ram_addr = rf_q[sr1] + off6;
            res_load = 1'b0;
          end
          OP_ST: begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = pcn + off9;
          end
          OP_STR: begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = rf_q[sr1] + off6;
          end
          OP_JSR: begin
            // target taken before r7 is overwritten
            pc_d  = ins[11] ? (pcn + off11) : rf_q[sr1];
            rf_we = 1'b1;
            rf_wa = 3'd7;
            rf_wd = pcn;
          end
          OP_JMP: pc_d = rf_q[sr1];
          OP_TRAP: begin
            unique case (ins[7:0])
              VEC_GETC: begin
                rf_we = 1'b1;
                rf_wa = 3'd0;
                rf_wd = {8'h00, key_q};
              end
              VEC_OUT: begin
                r_ov = 1'b1;
                r_oc = rf_q[0][7:0];
              end
              VEC_PUTS, VEC_PUTSP: r_status = STAT_STRING;
              VEC_HALT: begin
                halt_d   = 1'b1;
                r_status = STAT_HALT;
              end
              default: ;
            endcase
          end
          default: begin
            halt_d   = 1'b1;
            r_status = STAT_ILLEGAL;
          end
        endcase
        if (rf_we && op != OP_JSR && op != OP_TRAP) cc_d = cc_of(rf_wd);
      end
      S_MEM1: begin
        r_ins = ins_q;
        if (op == OP_LDI) begin
          ram_en   = 1'b1;
          ram_addr = ram_rd;
        end else if (op == OP_STI) begin
          ram_en   = 1'b1;
          ram_we   = 1'b1;
          ram_addr = ram_rd;
          res_load = 1'b1;
        end else begin
          rf_we    = 1'b1;
          rf_wd    = ram_rd;
          cc_d     = cc_of(ram_rd);
          res_load = 1'b1;
        end
      end
      S_MEM2: begin
        r_ins    = ins_q;
        rf_we    = 1'b1;
        rf_wd    = ram_rd;
        cc_d     = cc_of(ram_rd);
        res_load = 1'b1;
      end
      default: ;
    endcase
    if (cfg_valid_i && cfg_ready_o) pc_d = start_pc_i;
    r_pc = pc_d;
    r_cc = cc_d;
  end

  assign res_vld_d = res_load ? 1'b1 : (res_stall_i ? res_vld_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      pc_q      <= 16'h0000;
      cc_q      <= 3'b000;
      halt_q    <= 1'b0;
      res_vld_q <= 1'b0;
      for (int i = 0; i < 8; i++) rf_q[i] <= 16'h0000;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      pc_q      <= pc_d;
      cc_q      <= cc_d;
      halt_q    <= halt_d;
      res_vld_q <= res_vld_d;
      if (rf_we) rf_q[rf_wa] <= rf_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    ins_q <= ins_d;
    key_q <= key_d;
    if (res_load) begin
      pc_out_o     <= r_pc;
      instr_word_o <= r_ins;
      status_o     <= r_status;
      out_valid_o  <= r_ov;
      out_char_o   <= r_oc;
      cond_flags_o <= r_cc;
      read_data_o  <= r_rdata;
    end
  end

  assign res_valid_o = res_vld_q;

  `LC3_ASSERT(a_clear_blocks, (state_q != S_CLEAR) || in_stall_o, "input taken during clear")
  `LC3_ASSERT(a_peek_no_write, (state_q != S_PEEK) || !ram_we, "memory written during peek")
  `LC3_ASSERT_NEXT(a_halted_step, in_acc && kind_i == KIND_STEP && halt_q, res_vld_q && status_o == STAT_IGNORED, "halted step not reported")
  `LC3_ASSERT(a_halt_source, !$rose(halt_q) || $past(state_q) == S_FETCH, "halt set outside fetch")
  `LC3_ASSERT(a_busy_out_free, (state_q == S_IDLE) || (state_q == S_CLEAR) || !res_vld_q, "result pending while executing")
endmodule
`default_nettype wire
